// ===== rtl/hash_table_lookup_insert_defines.svh =====
// Assertion macros for the hash table block.
// Used by hash_table_lookup_insert.sv; expects clk and rst_n in scope.
`ifndef HASH_TABLE_LOOKUP_INSERT_DEFINES_SVH
`define HASH_TABLE_LOOKUP_INSERT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/htl_pkg.sv =====
// Shared types and constants for the hash table block.
// No dependencies.
package htl_pkg;

    localparam int KEY_W      = 64;
    localparam int IN_VALUE_W = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int COUNT_W    = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    // Key reduction: 8 key bits consumed per cycle until every key bit is used.
    localparam int HASH_STEP   = 8;
    localparam int HASH_CHUNKS = KEY_W / HASH_STEP;
    localparam int CHUNK_W     = $clog2(HASH_CHUNKS);

    typedef logic [0:0] opcode_t;
    localparam opcode_t OP_LOOKUP = 1'b0;
    localparam opcode_t OP_INSERT = 1'b1;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

// ===== rtl/hash_table_lookup_insert.sv =====
// Channel | signals                           | item accepted when
// --------+-----------------------------------+---------------------------
// in      | in_valid in_ready opcode key value| in_valid && in_ready
// out     | out_valid out_ready found         | out_valid && out_ready
//         | value_out bucket_full entry_count |
// An item passes from acceptance to ready through read, compare and write back
// when BUCKETS is a power of two; otherwise the key is first reduced modulo
// BUCKETS 8 bits per cycle until every key bit is used, before the row read.
// One item is in flight; the row memory is read, then written.
// After reset a clearing pass zeroes every row; no item is accepted during
// it. A stalled output holds the write-back cycle.
// Depends on htl_pkg and hash_table_lookup_insert_defines.svh.
`include "hash_table_lookup_insert_defines.svh"

module hash_table_lookup_insert #(
    parameter int BUCKETS    = 8,
    parameter int WAYS       = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  htl_pkg::opcode_t              opcode,
    input  htl_pkg::key_t                 key,
    input  logic [htl_pkg::IN_VALUE_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [htl_pkg::OUT_VALUE_W-1:0] value_out,
    output logic                          bucket_full,
    output htl_pkg::count_t               entry_count
);
    import htl_pkg::*;

    localparam int  BIDX_W      = $clog2(BUCKETS);
    localparam int  REM_W       = BIDX_W + 1;
    localparam bit  BUCKET_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam int  KEYS_W      = WAYS * KEY_W;
    localparam int  VALS_W      = WAYS * VALUE_BITS;
    localparam int  ROW_W       = KEYS_W + VALS_W + WAYS;
    localparam int  CAP         = (BUCKETS * WAYS > 63) ? 63 : BUCKETS * WAYS;
    localparam logic [REM_W-1:0]  BUCKETS_R  = REM_W'(BUCKETS);
    localparam logic [BIDX_W-1:0] LAST_ROW   = BIDX_W'(BUCKETS - 1);
    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(HASH_CHUNKS - 1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_HASH = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [BIDX_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [BIDX_W-1:0]     bucket_reg, bucket_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [CHUNK_W-1:0]    chunk_reg, chunk_next;
    key_t                  hash_sh_reg, hash_sh_next;
    opcode_t               op_reg;
    key_t                  key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [WAYS-1:0]       hit_vec_reg, free_vec_reg;
    count_t                load_count_reg, load_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg;
    logic [OUT_VALUE_W-1:0] value_out_reg;
    logic                  bucket_full_reg;

    logic [ROW_W-1:0]      row_mem [BUCKETS];
    logic [ROW_W-1:0]      rd_data_reg;
    logic                  mem_we;
    logic [BIDX_W-1:0]     mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    logic [WAYS-1:0][KEY_W-1:0]      rd_keys, wr_keys;
    logic [WAYS-1:0][VALUE_BITS-1:0] rd_vals, wr_vals;
    logic [WAYS-1:0]                 rd_valid, wr_valid;
    logic [WAYS-1:0]                 hit_oh, free_oh, upd_oh, fill_oh;
    logic [VALUE_BITS-1:0]           hit_val;
    logic                            any_hit, any_free, is_insert;
    logic                            accept, fin_fire;
    logic [REM_W-1:0]                rem_step;

    assign accept   = in_valid && in_ready;
    assign fin_fire = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign value_out   = value_out_reg;
    assign bucket_full = bucket_full_reg;
    assign entry_count = load_count_reg;

    // Reduce eight key bits per cycle, MSB first: r = (2r + bit) mod BUCKETS.
    always_comb
    begin
        rem_step = rem_reg;
        for (int i = 0; i < HASH_STEP; i++)
        begin
            rem_step = {rem_step[REM_W-2:0], hash_sh_reg[KEY_W-1-i]};
            if (rem_step >= BUCKETS_R)
            begin
                rem_step = rem_step - BUCKETS_R;
            end
        end
    end

    // Row fields and way selection.
    assign rd_keys  = rd_data_reg[KEYS_W-1:0];
    assign rd_vals  = rd_data_reg[KEYS_W +: VALS_W];
    assign rd_valid = rd_data_reg[KEYS_W + VALS_W +: WAYS];

    // Lowest set bit wins.
    assign hit_oh    = hit_vec_reg & (~hit_vec_reg + WAYS'(1));
    assign free_oh   = free_vec_reg & (~free_vec_reg + WAYS'(1));
    assign any_hit   = |hit_vec_reg;
    assign any_free  = |free_vec_reg;
    assign is_insert = (op_reg == OP_INSERT);
    assign upd_oh    = (is_insert && any_hit) ? hit_oh : '0;
    assign fill_oh   = (is_insert && !any_hit) ? free_oh : '0;

    always_comb
    begin
        hit_val  = '0;
        wr_keys  = rd_keys;
        wr_vals  = rd_vals;
        wr_valid = rd_valid;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit_oh[w])
            begin
                hit_val = hit_val | rd_vals[w];
            end
            if (upd_oh[w])
            begin
                wr_vals[w] = val_reg;
            end
            if (fill_oh[w])
            begin
                wr_keys[w]  = key_reg;
                wr_vals[w]  = val_reg;
                wr_valid[w] = 1'b1;
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = bucket_reg;
        mem_wdata = {wr_valid, wr_vals, wr_keys};
        if (state_reg == ST_CLR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (fin_fire && is_insert && (any_hit || any_free))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= row_mem[bucket_reg];
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        bucket_next     = bucket_reg;
        rem_next        = rem_reg;
        chunk_next      = chunk_reg;
        hash_sh_next    = hash_sh_reg;
        load_count_next = load_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLR:
            begin
                clr_idx_next = clr_idx_reg + BIDX_W'(1);
                if (clr_idx_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next     = '0;
                    chunk_next   = '0;
                    hash_sh_next = key;
                    if (BUCKET_POW2)
                    begin
                        bucket_next = key[BIDX_W-1:0];
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                rem_next     = rem_step;
                hash_sh_next = hash_sh_reg << HASH_STEP;
                chunk_next   = chunk_reg + CHUNK_W'(1);
                if (chunk_reg == LAST_CHUNK)
                begin
                    bucket_next = rem_step[BIDX_W-1:0];
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (is_insert && !any_hit && any_free && load_count_reg != COUNT_MAX)
                    begin
                        load_count_next = load_count_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_idx_reg    <= '0;
            load_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            load_count_reg <= load_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        bucket_reg  <= bucket_next;
        rem_reg     <= rem_next;
        chunk_reg   <= chunk_next;
        hash_sh_reg <= hash_sh_next;
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            val_reg <= VALUE_BITS'(value);
        end
        if (state_reg == ST_CMP)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                hit_vec_reg[w]  <= rd_valid[w] && (rd_keys[w] == key_reg);
                free_vec_reg[w] <= !rd_valid[w];
            end
        end
        if (fin_fire)
        begin
            found_reg       <= any_hit;
            value_out_reg   <= (!is_insert && any_hit) ? OUT_VALUE_W'(hit_val) : '0;
            bucket_full_reg <= is_insert && !any_hit && !any_free;
        end
    end

    `HTL_ASSERT_NEXT(a_fin_loads_out, fin_fire, out_valid, "result not presented after write-back")
    `HTL_ASSERT_NOW(a_count_cap, 1'b1, load_count_reg <= COUNT_W'(CAP), "entry count above capacity")
    `HTL_ASSERT_NEXT(a_count_step, 1'b1, load_count_reg == $past(load_count_reg) || load_count_reg == $past(load_count_reg) + COUNT_W'(1), "entry count moved by more than one")
    `HTL_ASSERT_NOW(a_full_clean, out_valid_reg && bucket_full_reg, !found_reg && value_out_reg == '0, "bucket full reported with hit or data")

endmodule

// ===== sim/tb_hash_table_lookup_insert.sv =====
// Self-checking bench for hash_table_lookup_insert: directed table, then random lookups/inserts.
// Expected replies: a typed row's own, else a bucket/way model. Depends on htl_pkg and the RTL.
module tb_hash_table_lookup_insert;
    import htl_pkg::*;

    localparam int BUCKETS    = 8;
    localparam int WAYS       = 4;
    localparam int VALUE_BITS = 32;
    localparam int SLOTS      = BUCKETS * WAYS;
    localparam int RANDOM_ITEMS = 1950;
    localparam int KEY_POOL     = 64;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;

    typedef logic [IN_VALUE_W-1:0] in_word_t;

    typedef struct packed {
        logic                   found;
        logic [OUT_VALUE_W-1:0] value_out;
        logic                   bucket_full;
        count_t                 entry_count;
    } table_reply_t;

    typedef struct packed {
        opcode_t      op;
        key_t         k;
        in_word_t     v;
        logic         typed;
        table_reply_t reply;
    } stim_row_t;

    localparam key_t KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam key_t KEY_B0_A = 64'h8000_0000_0000_0010;
    localparam key_t KEY_B0_B = 64'h5555_5555_5555_5558;
    localparam key_t KEY_B0_C = 64'hAAAA_AAAA_AAAA_AAA8;
    localparam key_t KEY_B0_D = 64'h8000_0000_0000_0000;
    localparam key_t KEY_B2   = 64'hAAAA_AAAA_AAAA_AAAA;

    // Rows with typed=0 are checked against the table model.
    localparam stim_row_t DIRECTED [21] = '{
        '{OP_LOOKUP, 64'd0,    32'd0,           1'b1, '{1'b0, 32'd0,          1'b0, 6'd0}},
        '{OP_INSERT, 64'd0,    32'hFFFF_FFFF,   1'b1, '{1'b0, 32'd0,          1'b0, 6'd1}},
        '{OP_LOOKUP, 64'd0,    32'd0,           1'b1, '{1'b1, 32'hFFFF_FFFF,  1'b0, 6'd1}},
        '{OP_INSERT, KEY_ONES, 32'd0,           1'b1, '{1'b0, 32'd0,          1'b0, 6'd2}},
        '{OP_LOOKUP, KEY_ONES, 32'hFFFF_FFFF,   1'b1, '{1'b1, 32'd0,          1'b0, 6'd2}},
        '{OP_INSERT, 64'd0,    32'h1234_5678,   1'b1, '{1'b1, 32'd0,          1'b0, 6'd2}},
        '{OP_LOOKUP, 64'd0,    32'd0,           1'b1, '{1'b1, 32'h1234_5678,  1'b0, 6'd2}},
        '{OP_INSERT, 64'd8,    32'hA5A5_A5A5,   1'b1, '{1'b0, 32'd0,          1'b0, 6'd3}},
        '{OP_INSERT, KEY_B0_A, 32'h5A5A_5A5A,   1'b1, '{1'b0, 32'd0,          1'b0, 6'd4}},
        '{OP_INSERT, KEY_B0_B, 32'd1,           1'b1, '{1'b0, 32'd0,          1'b0, 6'd5}},
        '{OP_INSERT, KEY_B0_C, 32'hDEAD_BEEF,   1'b1, '{1'b0, 32'd0,          1'b1, 6'd5}},
        '{OP_LOOKUP, KEY_B0_C, 32'd0,           1'b1, '{1'b0, 32'd0,          1'b0, 6'd5}},
        '{OP_INSERT, 64'd8,    32'd0,           1'b1, '{1'b1, 32'd0,          1'b0, 6'd5}},
        '{OP_LOOKUP, 64'd8,    32'd0,           1'b1, '{1'b1, 32'd0,          1'b0, 6'd5}},
        '{OP_LOOKUP, KEY_B0_D, 32'd0,           1'b1, '{1'b0, 32'd0,          1'b0, 6'd5}},
        '{OP_LOOKUP, 64'd7,    32'd0,           1'b1, '{1'b0, 32'd0,          1'b0, 6'd5}},
        '{OP_INSERT, 64'd7,    32'h8000_0001,   1'b0, '0},
        '{OP_LOOKUP, 64'd7,    32'd0,           1'b0, '0},
        '{OP_LOOKUP, KEY_B0_B, 32'd0,           1'b0, '0},
        '{OP_INSERT, KEY_B2,   32'hAAAA_AAAA,   1'b0, '0},
        '{OP_LOOKUP, KEY_B2,   32'd0,           1'b0, '0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    opcode_t    opcode;
    key_t       key;
    in_word_t   value;
    logic       out_valid;
    logic       out_ready;
    logic       found;
    logic [OUT_VALUE_W-1:0] value_out;
    logic       bucket_full;
    count_t     entry_count;

    // Table model state
    key_t                  slot_key  [SLOTS];
    logic [VALUE_BITS-1:0] slot_value[SLOTS];
    logic                  slot_used [SLOTS];
    count_t                stored_count;

    table_reply_t replies_due[$];
    key_t         pool_keys[KEY_POOL];
    int           fault_count;
    bit           gaps_on;
    bit           hold_req;

    hash_table_lookup_insert #(
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS),
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .value_out  (value_out),
        .bucket_full(bucket_full),
        .entry_count(entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Apply one item to the model table and return the reply it should give.
    function automatic table_reply_t table_apply(input opcode_t op, input key_t k,
                                                 input in_word_t v);
        table_reply_t r;
        int base;
        int hit;
        int free_way;
        r = '0;
        base = int'(k % 64'(BUCKETS)) * WAYS;
        hit = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (slot_used[base + w])
            begin
                if (hit < 0 && slot_key[base + w] == k)
                    hit = w;
            end
            else if (free_way < 0)
                free_way = w;
        end
        r.found = (hit >= 0);
        if (op == OP_LOOKUP)
        begin
            if (hit >= 0)
                r.value_out = OUT_VALUE_W'(slot_value[base + hit]);
        end
        else if (hit >= 0)
            slot_value[base + hit] = VALUE_BITS'(v);
        else if (free_way >= 0)
        begin
            slot_key[base + free_way]   = k;
            slot_value[base + free_way] = VALUE_BITS'(v);
            slot_used[base + free_way]  = 1'b1;
            if (stored_count != COUNT_MAX)
                stored_count = stored_count + 1'b1;
        end
        else
            r.bucket_full = 1'b1;
        r.entry_count = stored_count;
        return r;
    endfunction

    // Offer one item, hold it until accepted, then record its expected reply.
    task automatic offer_item(input opcode_t op, input key_t k, input in_word_t v,
                              input logic typed, input table_reply_t typed_reply);
        table_reply_t r;
        if (gaps_on && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = table_apply(op, k, v);
        replies_due.push_back(typed ? typed_reply : r);
    endtask

    initial
    begin : ready_driver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (gaps_on)
                out_ready <= ($urandom_range(99) >= 23);
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : reply_check
        table_reply_t want;
        table_reply_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{found, value_out, bucket_full, entry_count};
            if (replies_due.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected reply found=%0b value=%h full=%0b count=%0d",
                         $time, got.found, got.value_out, got.bucket_full, got.entry_count);
            end
            else
            begin
                want = replies_due.pop_front();
                if (got !== want)
                begin
                    fault_count++;
                    // fields in order: found / value_out / bucket_full / entry_count
                    $display("%0t: mismatch expected %0b/%h/%0b/%0d actual %0b/%h/%0b/%0d",
                             $time, want.found, want.value_out, want.bucket_full,
                             want.entry_count, got.found, got.value_out,
                             got.bucket_full, got.entry_count);
                end
            end
        end
    end

    initial
    begin : stimulus
        opcode_t  op;
        key_t     k;
        in_word_t v;
        int       pool_size;
        fault_count  = 0;
        gaps_on      = 1'b1;
        hold_req     = 1'b0;
        stored_count = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_used[i]  = 1'b0;
        end
        for (int i = 0; i < KEY_POOL; i++)
            pool_keys[i] = {$urandom, $urandom};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        opcode   = OP_LOOKUP;
        key      = '0;
        value    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            offer_item(DIRECTED[i].op, DIRECTED[i].k, DIRECTED[i].v,
                       DIRECTED[i].typed, DIRECTED[i].reply);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 600 && n < 900);
            if (n == 1000)
                hold_req = 1'b1;
            // let the block drain completely once
            if (n == 1400)
            begin
                in_valid <= 1'b0;
                while (replies_due.size() != 0)
                    @(posedge clk);
            end
            // widen the key pool slowly so buckets fill gradually
            pool_size = (8 + n / 30 > KEY_POOL) ? KEY_POOL : 8 + n / 30;
            op = ($urandom_range(99) < 45) ? OP_LOOKUP : OP_INSERT;
            if ($urandom_range(99) < 85)
                k = pool_keys[$urandom_range(pool_size - 1)];
            else
                k = {$urandom, $urandom};
            case ($urandom_range(19))
                0:       v = '0;
                1:       v = '1;
                default: v = $urandom;
            endcase
            offer_item(op, k, v, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
